### rtl/core/tcbe_pkg.sv
`default_nettype none

package tcbe_pkg;

	// Default grid size in cells.
	localparam int DEF_GRID_COLS = 64;
	localparam int DEF_GRID_ROWS = 32;

	// Command codes carried on the action port.
	typedef enum logic [2:0] {
		ACT_PUT   = 3'd0,
		ACT_GET   = 3'd1,
		ACT_CLEAR = 3'd2,
		ACT_UP    = 3'd3,
		ACT_DOWN  = 3'd4,
		ACT_LEFT  = 3'd5,
		ACT_RIGHT = 3'd6
	} action_t;

	// One character cell as it sits in the store.
	typedef struct packed {
		logic [3:0] fore;
		logic [3:0] back;
		logic [7:0] code;
	} cell_t;

	// White-on-black space, the content of every cell after reset.
	localparam cell_t RESET_CELL = '{fore: 4'hF, back: 4'h0, code: 8'h20};

endpackage

`default_nettype wire

### rtl/core/text_cell_buffer_engine_top.sv
`default_nettype none

// Text-mode cell store of GRID_COLS x GRID_ROWS cells held in one synchronous RAM with a single
// read and a single write port. A command is taken when start is high and busy is low. A put
// writes the cell and busy stays low. A get does the RAM read, then one cycle with valid high
// and the cell on read_fore, read_back and read_char. The receiver cannot stall, so the result
// must be captured in that cycle. Clear and scroll walk every grid cell through the RAM ports,
// one cell per cycle, copying from the source cell or writing the fill cell; busy stays high
// from the command until the walk and its drain step are done. A scroll by zero and an unused
// action code finish in the cycle they are taken. After reset the same walk fills the grid with
// white-on-black spaces, so busy is high until it is done and the first command can be taken.
module text_cell_buffer_engine_top
	import tcbe_pkg::*;
#(
	parameter int GRID_COLS = DEF_GRID_COLS,
	parameter int GRID_ROWS = DEF_GRID_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic signed [10:0] col,
	input  logic signed [10:0] row,
	input  logic [7:0]         amount,
	input  logic [3:0]         fore_colour,
	input  logic [3:0]         back_colour,
	input  logic [7:0]         char_code,
	output logic               valid,
	output logic [3:0]         read_fore,
	output logic [3:0]         read_back,
	output logic [7:0]         read_char
);

	localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GET,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	state_t          state_q;
	action_t         act_q;
	cell_t           fill_q;
	logic [7:0]      n_q;
	logic [RW-1:0]   y_q;
	logic [CW-1:0]   x_q;
	logic            inside_q;
	logic            wr_valid_s1;
	logic [AW-1:0]   wr_addr_s1;
	logic            wr_fill_s1;

	cell_t           mem [DEPTH];
	cell_t           rd_q;

	logic            accept;
	action_t         act_in;
	cell_t           cell_in;
	logic            in_grid;
	logic [AW-1:0]   in_addr;
	logic            desc_in;
	logic [9:0]      ey;
	logic [9:0]      ex;
	logic            src_ok;
	logic [RW-1:0]   src_y;
	logic [CW-1:0]   src_x;
	logic            descending;
	logic            last_cell;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	cell_t           mem_wdata;
	logic [AW-1:0]   mem_raddr;

	// Command decode and grid bounds check of the incoming transaction.
	assign accept  = start && !busy;
	assign act_in  = action_t'(action);
	assign cell_in = '{fore: fore_colour, back: back_colour, code: char_code};
	assign in_grid = !col[10] && !row[10]
		&& ($unsigned(col) < 11'(GRID_COLS)) && ($unsigned(row) < 11'(GRID_ROWS));
	assign in_addr = {row[RW-1:0], col[CW-1:0]};
	assign desc_in = (act_in == ACT_DOWN) || (act_in == ACT_RIGHT);

	// Source cell of the destination under the sweep; out of grid means fill.
	assign ey = 10'(y_q) + 10'(n_q);
	assign ex = 10'(x_q) + 10'(n_q);

	always_comb begin
		src_ok = 1'b0;
		src_y  = y_q;
		src_x  = x_q;
		case (act_q)
			ACT_UP: begin
				src_ok = ey < 10'(GRID_ROWS);
				src_y  = ey[RW-1:0];
			end
			ACT_DOWN: begin
				src_ok = 10'(y_q) >= 10'(n_q);
				src_y  = RW'(10'(y_q) - 10'(n_q));
			end
			ACT_LEFT: begin
				src_ok = ex < 10'(GRID_COLS);
				src_x  = ex[CW-1:0];
			end
			ACT_RIGHT: begin
				src_ok = 10'(x_q) >= 10'(n_q);
				src_x  = CW'(10'(x_q) - 10'(n_q));
			end
			default: begin
				src_ok = 1'b0;
			end
		endcase
	end

	// Down and right walk from the last cell backward so that every source is read
	// before it is overwritten; the others walk forward.
	assign descending = (act_q == ACT_DOWN) || (act_q == ACT_RIGHT);
	assign last_cell  = descending ? ((y_q == '0) && (x_q == '0))
		: ((y_q == RW'(GRID_ROWS - 1)) && (x_q == CW'(GRID_COLS - 1)));

	// RAM port selection. The sweep write comes in the cycle after its read and, whenever
	// the read supplies a copied cell, never hits the address read in the same cycle.
	assign mem_we    = wr_valid_s1 || (accept && (act_in == ACT_PUT) && in_grid);
	assign mem_waddr = wr_valid_s1 ? wr_addr_s1 : in_addr;
	assign mem_wdata = wr_valid_s1 ? (wr_fill_s1 ? fill_q : rd_q) : cell_in;
	assign mem_raddr = (state_q == ST_SWEEP) ? {src_y, src_x} : in_addr;

	// Cell store.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	// Command sequencer and sweep counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			act_q       <= ACT_CLEAR;
			fill_q      <= RESET_CELL;
			n_q         <= '0;
			y_q         <= '0;
			x_q         <= '0;
			inside_q    <= 1'b0;
			wr_valid_s1 <= 1'b0;
			wr_addr_s1  <= '0;
			wr_fill_s1  <= 1'b0;
		end else begin
			wr_valid_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (act_in)
							ACT_GET: begin
								inside_q <= in_grid;
								state_q  <= ST_GET;
							end
							ACT_CLEAR, ACT_UP, ACT_DOWN, ACT_LEFT, ACT_RIGHT: begin
								if ((act_in == ACT_CLEAR) || (amount != '0)) begin
									act_q   <= act_in;
									fill_q  <= cell_in;
									n_q     <= amount;
									y_q     <= desc_in ? RW'(GRID_ROWS - 1) : '0;
									x_q     <= desc_in ? CW'(GRID_COLS - 1) : '0;
									state_q <= ST_SWEEP;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_GET: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					wr_valid_s1 <= 1'b1;
					wr_addr_s1  <= {y_q, x_q};
					wr_fill_s1  <= !src_ok;
					if (last_cell) begin
						state_q <= ST_DRAIN;
					end else if (descending) begin
						if (x_q == '0) begin
							x_q <= CW'(GRID_COLS - 1);
							y_q <= y_q - RW'(1);
						end else begin
							x_q <= x_q - CW'(1);
						end
					end else begin
						if (x_q == CW'(GRID_COLS - 1)) begin
							x_q <= '0;
							y_q <= y_q + RW'(1);
						end else begin
							x_q <= x_q + CW'(1);
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result of a get; a cell outside the grid reads as all zero.
	assign busy      = (state_q != ST_IDLE);
	assign valid     = (state_q == ST_GET);
	assign read_fore = inside_q ? rd_q.fore : '0;
	assign read_back = inside_q ? rd_q.back : '0;
	assign read_char = inside_q ? rd_q.code : '0;

endmodule

`default_nettype wire

### rtl/core/tcbe_checker.sv
`default_nettype none

module tcbe_checker
	import tcbe_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [2:0]         action,
	input logic signed [10:0] col,
	input logic signed [10:0] row,
	input logic               valid,
	input logic [3:0]         read_fore,
	input logic [3:0]         read_back,
	input logic [7:0]         read_char
);

	// Every get transaction produces its result in the following cycle.
	a_get_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_GET) |=> valid)
		else $error("get transaction without result");

	// A result only ever follows a get transaction.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(start && !busy && (action == ACT_GET)))
		else $error("result without a get transaction");

	// No transaction is taken while a result is being shown.
	a_busy_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy)
		else $error("ready while a result is shown");

	// A get at a negative coordinate returns an all-zero cell.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_GET) && (col[10] || row[10])
		|=> (read_fore == '0) && (read_back == '0) && (read_char == '0))
		else $error("get outside the grid returned a nonzero cell");

	// A clear always occupies the block while it walks the grid.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_CLEAR) |=> busy)
		else $error("clear did not hold off the next transaction");

endmodule

bind text_cell_buffer_engine_top tcbe_checker u_tcbe_checker (.*);

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
	import tcbe_pkg::*;

	localparam int COLS = DEF_GRID_COLS;
	localparam int ROWS = DEF_GRID_ROWS;
	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 450;
	localparam int IDLE_PERCENT = 34;
	localparam int DRAIN_CYCLES = 8;
	// A clear or scroll walks the whole grid; this covers every command being one.
	localparam int CYCLE_LIMIT = 4_000_000;

	// The one action code that the package leaves unnamed.
	localparam logic [2:0] ACT_SPARE = 3'd7;

	// One command transaction as the testbench builds it.
	typedef struct {
		logic [2:0]         act;
		logic signed [10:0] col;
		logic signed [10:0] row;
		logic [7:0]         amount;
		cell_t              fill;
	} command_t;

	// Shadow copy of the cell grid plus the cells that outstanding gets must return.
	class screen_tracker;
		cell_t shadow_cells [ROWS][COLS];
		cell_t cells_due [$];
		int errors;

		function new();
			foreach (shadow_cells[y, x])
				shadow_cells[y][x] = RESET_CELL;
			errors = 0;
		endfunction

		// Applies one accepted transaction to the shadow grid; a get queues the cell it reads.
		function void note_command(command_t c);
			cell_t prior [ROWS][COLS];
			int dy;
			int dx;
			int sy;
			int sx;
			bit on_grid;
			dy = 0;
			dx = 0;
			on_grid = c.col >= 0 && c.col < COLS && c.row >= 0 && c.row < ROWS;
			case (c.act)
				ACT_PUT: if (on_grid) shadow_cells[c.row][c.col] = c.fill;
				ACT_GET: cells_due.push_back(on_grid ? shadow_cells[c.row][c.col] : cell_t'(16'h0));
				ACT_CLEAR: dy = ROWS;
				ACT_UP: dy = int'(c.amount);
				ACT_DOWN: dy = -int'(c.amount);
				ACT_LEFT: dx = int'(c.amount);
				ACT_RIGHT: dx = -int'(c.amount);
				default: ;
			endcase
			// Clear and scroll shift every cell by (dy, dx); cells without a source take the fill.
			if (dy != 0 || dx != 0) begin
				prior = shadow_cells;
				foreach (shadow_cells[y, x]) begin
					sy = y + dy;
					sx = x + dx;
					shadow_cells[y][x] = (sy >= 0 && sy < ROWS && sx >= 0 && sx < COLS) ?
						prior[sy][sx] : c.fill;
				end
			end
		endfunction

		// Compares one read result with the oldest outstanding get.
		function void check_read(logic [3:0] fore, logic [3:0] back, logic [7:0] code);
			cell_t due;
			if (cells_due.size() == 0) begin
				$error("read result with no get outstanding: fore %0d back %0d char 0x%02h",
					fore, back, code);
				errors++;
				return;
			end
			due = cells_due.pop_front();
			if (fore !== due.fore) begin
				$error("read_fore: expected %0d, got %0d", due.fore, fore);
				errors++;
			end
			if (back !== due.back) begin
				$error("read_back: expected %0d, got %0d", due.back, back);
				errors++;
			end
			if (code !== due.code) begin
				$error("read_char: expected 0x%02h, got 0x%02h", due.code, code);
				errors++;
			end
		endfunction

		// Any get still waiting at the end never produced its result.
		function void close();
			if (cells_due.size() != 0) begin
				$error("%0d get results never arrived", cells_due.size());
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         action = ACT_PUT;
	logic signed [10:0] col = '0;
	logic signed [10:0] row = '0;
	logic [7:0]         amount = '0;
	logic [3:0]         fore_colour = '0;
	logic [3:0]         back_colour = '0;
	logic [7:0]         char_code = '0;
	logic               valid;
	logic [3:0]         read_fore;
	logic [3:0]         read_back;
	logic [7:0]         read_char;

	screen_tracker tracker = new();
	bit steady = 1'b0;
	int cycle_count = 0;

	text_cell_buffer_engine_top #(
		.GRID_COLS(COLS),
		.GRID_ROWS(ROWS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.col(col),
		.row(row),
		.amount(amount),
		.fore_colour(fore_colour),
		.back_colour(back_colour),
		.char_code(char_code),
		.valid(valid),
		.read_fore(read_fore),
		.read_back(read_back),
		.read_char(read_char)
	);

	always #HALF_PERIOD clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Every read result is checked in the one cycle it is shown.
	always @(posedge clk) begin
		if (arst_n && valid === 1'b1)
			tracker.check_read(read_fore, read_back, read_char);
	end

	function automatic command_t make_command(logic [2:0] act, int c, int r, int amt,
		int f, int b, int ch);
		command_t x;
		x.act = act;
		x.col = 11'(c);
		x.row = 11'(r);
		x.amount = 8'(amt);
		x.fill = '{fore: 4'(f), back: 4'(b), code: 8'(ch)};
		return x;
	endfunction

	// Mostly a coordinate on the grid, sometimes any value the port can carry.
	function automatic logic signed [10:0] pick_coord(int span);
		if ($urandom_range(9) == 0)
			return 11'($urandom);
		return 11'($urandom_range(span - 1));
	endfunction

	// Drives one command and waits until the block takes the transaction.
	task automatic issue_command(input command_t c);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				start <= 1'b0;
				action <= 3'($urandom);
				col <= 11'($urandom);
				row <= 11'($urandom);
				char_code <= 8'($urandom);
				@(posedge clk);
			end
		end
		start <= 1'b1;
		action <= c.act;
		col <= c.col;
		row <= c.row;
		amount <= c.amount;
		fore_colour <= c.fill.fore;
		back_colour <= c.fill.back;
		char_code <= c.fill.code;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_command(c);
	endtask

	initial begin
		command_t c;
		int pick;
		int dim;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset content, grid corners and gets off the grid.
		issue_command(make_command(ACT_GET, 0, 0, 0, 0, 0, 0));
		issue_command(make_command(ACT_GET, COLS - 1, ROWS - 1, 0, 0, 0, 0));
		issue_command(make_command(ACT_GET, -1, 0, 0, 15, 15, 255));
		issue_command(make_command(ACT_GET, 0, ROWS, 0, 0, 0, 0));
		// Puts at the corners with extreme cells; puts off the grid must change nothing.
		issue_command(make_command(ACT_PUT, 0, 0, 0, 0, 15, 255));
		issue_command(make_command(ACT_PUT, COLS - 1, ROWS - 1, 255, 15, 0, 0));
		issue_command(make_command(ACT_PUT, -1, 5, 0, 1, 2, 3));
		issue_command(make_command(ACT_PUT, COLS, 0, 0, 4, 5, 6));
		issue_command(make_command(ACT_PUT, 5, ROWS, 0, 7, 8, 9));
		issue_command(make_command(ACT_PUT, -1024, 1023, 0, 10, 11, 12));
		issue_command(make_command(ACT_GET, 0, 0, 0, 0, 0, 0));
		issue_command(make_command(ACT_GET, COLS - 1, ROWS - 1, 0, 0, 0, 0));
		issue_command(make_command(ACT_GET, 1023, -1024, 0, 0, 0, 0));
		// Scrolls by one, by zero and by one less than the dimension, then the unused code.
		issue_command(make_command(ACT_UP, 0, 0, 1, 3, 4, 8'h41));
		issue_command(make_command(ACT_DOWN, 0, 0, 0, 5, 6, 8'h42));
		issue_command(make_command(ACT_LEFT, 0, 0, 1, 7, 8, 8'h43));
		issue_command(make_command(ACT_RIGHT, 0, 0, COLS - 1, 9, 10, 8'h44));
		issue_command(make_command(ACT_DOWN, 0, 0, ROWS - 1, 11, 12, 8'h45));
		issue_command(make_command(ACT_SPARE, 3, 3, 7, 1, 1, 1));
		issue_command(make_command(ACT_GET, 0, 0, 0, 0, 0, 0));
		issue_command(make_command(ACT_GET, COLS - 1, 0, 0, 0, 0, 0));
		// Scrolls of at least the dimension and a clear fill the whole grid.
		issue_command(make_command(ACT_UP, 0, 0, ROWS, 2, 3, 8'h7E));
		issue_command(make_command(ACT_LEFT, 0, 0, 255, 4, 5, 8'h80));
		issue_command(make_command(ACT_GET, 20, 20, 0, 0, 0, 0));
		issue_command(make_command(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
		issue_command(make_command(ACT_GET, 10, 10, 0, 0, 0, 0));

		// Random traffic: mostly puts and gets on the grid, some scrolls and clears.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 200 && i < 300);
			pick = $urandom_range(99);
			c.col = pick_coord(COLS);
			c.row = pick_coord(ROWS);
			c.amount = 8'($urandom);
			c.fill = cell_t'(16'($urandom));
			if (pick < 40)
				c.act = ACT_PUT;
			else if (pick < 80)
				c.act = ACT_GET;
			else if (pick < 83)
				c.act = ACT_CLEAR;
			else if (pick < 97) begin
				c.act = 3'($urandom_range(ACT_UP, ACT_RIGHT));
				dim = (c.act == ACT_UP || c.act == ACT_DOWN) ? ROWS : COLS;
				pick = $urandom_range(9);
				if (pick < 6)
					c.amount = 8'($urandom_range(1, 4));
				else if (pick < 9)
					c.amount = 8'($urandom_range(dim));
			end else
				c.act = ACT_SPARE;
			issue_command(c);
		end
		steady = 1'b0;
		start <= 1'b0;

		// Let the last get results come out before the verdict.
		while (tracker.cells_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		tracker.close();
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
rtl/core/tcbe_pkg.sv
rtl/core/text_cell_buffer_engine_top.sv
rtl/core/tcbe_checker.sv
tb/tb.sv
